// ===== hw/rtl/log_fixed_point_unit_macros.svh =====
// Assertion macros used by the checker file of the log unit.
`ifndef LOG_FIXED_POINT_UNIT_MACROS_SVH
`define LOG_FIXED_POINT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define LFP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define LFP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lfp_pkg.sv =====
// Package of the log unit: widths, constants, state and control types.
package lfp_pkg;

    // Number format
    localparam int FRAC_BITS = 26;
    localparam int OPND_W    = 58;
    localparam int RES_W     = 32;
    localparam int S_TDATA_W = ((OPND_W + 7) / 8) * 8;

    // Whole part of log2 spans -FRAC_BITS to OPND_W-FRAC_BITS-1
    localparam int IP_W   = $clog2(OPND_W) + 2;
    localparam int ACC_W  = IP_W + FRAC_BITS;
    localparam int SAT_W  = ((ACC_W > RES_W) ? ACC_W : RES_W) + 1;
    localparam int CNT_W  = $clog2(FRAC_BITS);
    localparam int SQ_W   = FRAC_BITS + 2;

    // Shared multiplier and ln2 scaling
    localparam int MUL_W    = 32;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int LN_SHIFT = 31;
    localparam logic [MUL_W-1:0] LN2_Q1_31 = 32'h58b9_0bfc;
    localparam logic [RES_W-1:0] RES_MIN   = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] RES_MAX   = {1'b0, {(RES_W-1){1'b1}}};

    // Register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_IDX_MODE = '0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_SQR,
        ST_SCALE,
        ST_FINAL
    } lfp_state_t;

    // Sequencer to datapath
    typedef struct packed {
        logic load;
        logic norm;
        logic sqr;
        logic scale;
        logic finish;
    } lfp_ctrl_t;

    // Datapath to sequencer
    typedef struct packed {
        logic zero_op;
        logic below_one;
        logic above_two;
    } lfp_stat_t;

endpackage

// ===== hw/rtl/lfp_mul.sv =====
// Shared unsigned multiplier used for squaring and for ln2 scaling.
module lfp_mul
    import lfp_pkg::*;
(
    input  logic [MUL_W-1:0]  mul_a,
    input  logic [MUL_W-1:0]  mul_b,
    output logic [PROD_W-1:0] mul_p
);

    assign mul_p = {{MUL_W{1'b0}}, mul_a} * {{MUL_W{1'b0}}, mul_b};

endmodule

// ===== hw/rtl/lfp_seq.sv =====
// Sequencer of the log unit: state machine, bit counter, output valid.
module lfp_seq
    import lfp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    input  logic      natural_mode,
    input  lfp_stat_t stat,
    output lfp_ctrl_t ctrl
);

    lfp_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             out_free;
    logic             in_range;

    assign out_free = !m_tvalid_reg || m_tready;
    assign in_range = !stat.below_one && !stat.above_two;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = stat.zero_op ? ST_FINAL : ST_NORM;
                end
            end
            ST_NORM: begin
                if (in_range) begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                if (cnt_reg == '0) begin
                    state_next = natural_mode ? ST_SCALE : ST_FINAL;
                end
            end
            ST_SCALE: state_next = ST_FINAL;
            ST_FINAL: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the state machine
    always_comb begin
        ctrl     = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                ctrl.load = s_tvalid;
            end
            ST_NORM:  ctrl.norm   = 1'b1;
            ST_SQR:   ctrl.sqr    = 1'b1;
            ST_SCALE: ctrl.scale  = 1'b1;
            ST_FINAL: ctrl.finish = out_free;
            default:  ctrl        = '0;
        endcase
    end

    // Fraction bit counter, loaded when the operand lands in [1,2)
    always_comb begin
        cnt_next = cnt_reg;
        if (state_reg == ST_NORM && in_range) begin
            cnt_next = CNT_W'(FRAC_BITS - 1);
        end else if (state_reg == ST_SQR) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    // Output item valid, held until taken
    assign m_tvalid_next = ctrl.finish || (m_tvalid_reg && !m_tready);
    assign m_tvalid      = m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

endmodule

// ===== hw/rtl/lfp_dp.sv =====
// Datapath of the log unit: operand shifter, result bits, scaling, output.
module lfp_dp
    import lfp_pkg::*;
(
    input  logic              aclk,
    input  logic [OPND_W-1:0] operand_value,
    input  logic              natural_mode,
    input  lfp_ctrl_t         ctrl,
    output lfp_stat_t         stat,
    output logic [MUL_W-1:0]  mul_a,
    output logic [MUL_W-1:0]  mul_b,
    input  logic [PROD_W-1:0] mul_p,
    output logic [RES_W-1:0]  log_result,
    output logic              zero_input
);

    logic [OPND_W-1:0]       z_reg, z_next;
    logic signed [IP_W-1:0]  ip_reg, ip_next;
    logic [FRAC_BITS-1:0]    frac_reg, frac_next;
    logic                    zero_reg, zero_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic [RES_W-1:0]        res_reg, res_next;
    logic                    zflag_reg, zflag_next;

    logic signed [ACC_W-1:0] acc;
    logic [SAT_W-1:0]        acc_ext;
    logic [SAT_W-RES_W:0]    acc_top;
    logic [RES_W-1:0]        acc_sat;
    logic                    acc_neg;
    logic [MUL_W-1:0]        acc_mag;
    logic [SQ_W-1:0]         sq;
    logic [PROD_W-1:0]       prod_signed;

    // Zero flag of the input operand, range flags of the working operand
    assign stat.zero_op   = (operand_value == '0);
    assign stat.below_one = (z_reg[OPND_W-1:FRAC_BITS] == '0);
    assign stat.above_two = |z_reg[OPND_W-1:FRAC_BITS+1];

    // Base-2 result, saturated to the result width
    assign acc     = {ip_reg, frac_reg};
    assign acc_ext = {{(SAT_W-ACC_W){acc[ACC_W-1]}}, acc};
    assign acc_top = acc_ext[SAT_W-1:RES_W-1];
    always_comb begin
        if ((&acc_top) || !(|acc_top)) begin
            acc_sat = acc_ext[RES_W-1:0];
        end else begin
            acc_sat = acc_top[SAT_W-RES_W] ? RES_MIN : RES_MAX;
        end
    end
    assign acc_neg = acc_sat[RES_W-1];
    assign acc_mag = acc_neg ? MUL_W'(~acc_sat + RES_W'(1)) : MUL_W'(acc_sat);

    // Multiplier operands: square of z, or |log2| times ln2
    always_comb begin
        if (ctrl.scale) begin
            mul_a = acc_mag;
            mul_b = LN2_Q1_31;
        end else begin
            mul_a = MUL_W'(z_reg[FRAC_BITS:0]);
            mul_b = MUL_W'(z_reg[FRAC_BITS:0]);
        end
    end

    // Square truncated back to FRAC_BITS fraction bits, in [1,4)
    assign sq = mul_p[FRAC_BITS +: SQ_W];

    // Signed scaled product, floor shift applied at the output
    assign prod_signed = acc_neg ? (~prod_reg + PROD_W'(1)) : prod_reg;

    // Working registers
    always_comb begin
        z_next     = z_reg;
        ip_next    = ip_reg;
        frac_next  = frac_reg;
        zero_next  = zero_reg;
        prod_next  = prod_reg;
        res_next   = res_reg;
        zflag_next = zflag_reg;
        if (ctrl.load) begin
            z_next    = operand_value;
            ip_next   = '0;
            zero_next = stat.zero_op;
        end
        if (ctrl.norm) begin
            if (stat.below_one) begin
                z_next  = {z_reg[OPND_W-2:0], 1'b0};
                ip_next = ip_reg - IP_W'(1);
            end else if (stat.above_two) begin
                z_next  = {1'b0, z_reg[OPND_W-1:1]};
                ip_next = ip_reg + IP_W'(1);
            end
        end
        if (ctrl.sqr) begin
            z_next    = sq[SQ_W-1] ? OPND_W'(sq[SQ_W-1:1]) : OPND_W'(sq);
            frac_next = {frac_reg[FRAC_BITS-2:0], sq[SQ_W-1]};
        end
        if (ctrl.scale) begin
            prod_next = mul_p;
        end
        if (ctrl.finish) begin
            zflag_next = zero_reg;
            if (zero_reg) begin
                res_next = RES_MIN;
            end else if (natural_mode) begin
                res_next = prod_signed[LN_SHIFT +: RES_W];
            end else begin
                res_next = acc_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        z_reg     <= z_next;
        ip_reg    <= ip_next;
        frac_reg  <= frac_next;
        zero_reg  <= zero_next;
        prod_reg  <= prod_next;
        res_reg   <= res_next;
        zflag_reg <= zflag_next;
    end

    assign log_result = res_reg;
    assign zero_input = zflag_reg;

endmodule

// ===== hw/rtl/log_fixed_point_unit.sv =====
// Top level of the fixed-point logarithm unit: stream ports and register port.
//
// Computes log2 (or ln, in natural-log mode) of an unsigned operand with 26
// fraction bits, giving a signed result with 26 fraction bits. One item at a
// time: after an input item is taken, s_tready stays low until the result has
// been placed in the output register. An item is loaded, then normalized by
// single-bit shifts until the operand lies in [1,2) (0 to 31 shifts), then
// squared once per result fraction bit, all through the one shared 32x32
// multiplier, then scaled by ln2 in natural-log mode, and then written to the
// output register once that register is free. A zero operand skips the
// arithmetic, returning the most negative value with m_tuser set. The output
// register lets the next item be taken while a result waits on m_tready.
// Register 0 (byte address 0) is natural_log_mode, reset 1.
module log_fixed_point_unit
    import lfp_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input item
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [57:0] operand_value
    // Result item
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [RES_W-1:0]     m_tdata,   // [31:0] log_result
    output logic                 m_tuser,   // [0] zero_input
    // Register port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    logic              mode_reg, mode_next;
    logic              cfg_wr;
    lfp_ctrl_t         ctrl;
    lfp_stat_t         stat;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] mul_p;

    // Register port: always ready, one register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        mode_next = mode_reg;
        if (cfg_wr && paddr[PADDR_W-1:2] == REG_IDX_MODE) begin
            mode_next = pwdata[0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_IDX_MODE) ? PDATA_W'(mode_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else begin
            mode_reg <= mode_next;
        end
    end

    lfp_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .natural_mode (mode_reg),
        .stat         (stat),
        .ctrl         (ctrl)
    );

    lfp_dp u_dp (
        .aclk          (aclk),
        .operand_value (s_tdata[OPND_W-1:0]),
        .natural_mode  (mode_reg),
        .ctrl          (ctrl),
        .stat          (stat),
        .mul_a         (mul_a),
        .mul_b         (mul_b),
        .mul_p         (mul_p),
        .log_result    (m_tdata),
        .zero_input    (m_tuser)
    );

    lfp_mul u_mul (
        .mul_a (mul_a),
        .mul_b (mul_b),
        .mul_p (mul_p)
    );

endmodule

// ===== hw/rtl/lfp_checker.sv =====
// Port-level checks of the log unit, bound to the top level.
`include "log_fixed_point_unit_macros.svh"

module lfp_checker
    import lfp_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [RES_W-1:0] m_tdata,
    input logic             m_tuser
);

    // A waiting result holds still
    `LFP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // Zero flag always comes with the most negative value
    `LFP_ASSERT_IMP(a_zero_value, m_tvalid && m_tuser, m_tdata == RES_MIN, "zero flag without most negative result")

    // Busy right after an item is taken
    `LFP_ASSERT_NXT(a_busy, s_tvalid && s_tready, !s_tready, "input taken while busy")

endmodule

bind log_fixed_point_unit lfp_checker u_lfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
